### rtl/pcdt_pkg.sv
package pcdt_pkg;

  localparam int CHANNELS    = 64;
  localparam int ENERGY_BITS = 32;
  localparam int AW          = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAVE_INTERVAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOSE_SCALE    = 1'b1;

  localparam logic OP_DEPOSIT = 1'b0;
  localparam logic OP_EOE     = 1'b1;

  localparam logic [15:0] SAVE_INTERVAL_RST = 16'd1;
  localparam logic [31:0] DOSE_SCALE_RST    = 32'd65536;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEP,
    S_EOE_RD,
    S_EOE_MUL,
    S_EOE_WR,
    S_EOE_END,
    S_MOD_GO,
    S_MOD_WAIT,
    S_REP_SCAN,
    S_REP_LOAD,
    S_REP_CALC,
    S_REP_OUT
  } top_state_e;

  typedef enum logic [3:0] {
    R_IDLE,
    R_S2,
    R_TD,
    R_DIV1,
    R_DSS,
    R_DIV2,
    R_SQ,
    R_DIV3,
    R_SQRT,
    R_MOD,
    R_DONE
  } row_state_e;

  typedef enum logic {
    MODE_ROW,
    MODE_MOD
  } mode_e;

  typedef struct packed {
    logic  start;
    mode_e mode;
  } req_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } rsp_t;

  typedef struct packed {
    logic [63:0] td;
    logic [63:0] dse;
    logic [63:0] dss;
    logic [63:0] mds;
    logic [63:0] three;
  } row_t;

endpackage

### rtl/pcdt_row.sv
module pcdt_row (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pcdt_pkg::req_t    req_i,
  input  logic [63:0]       run_i,
  input  logic [63:0]       sq_i,
  input  logic [31:0]       scale_i,
  input  logic [31:0]       count_i,
  input  logic [15:0]       interval_i,
  output pcdt_pkg::rsp_t    rsp_o,
  output pcdt_pkg::row_t    row_o
);

  pcdt_pkg::row_state_e state_q, state_d;

  logic [63:0]  run_q, sq_q, s2_q;
  logic [31:0]  sc_q, n_q;
  logic [63:0]  op_a_q, op_b_q;
  logic [1:0]   klast_q;
  logic [2:0]   mcnt_q;
  logic [63:0]  p_q;
  logic [1:0]   p_sh_q;
  logic         p_vld_q;
  logic [127:0] acc_q, acc_d;
  logic [63:0]  dvd_q;
  logic [31:0]  dvs_q, rem_q;
  logic [5:0]   dcnt_q;
  logic [63:0]  rad_q;
  logic [33:0]  srem_q;
  logic [31:0]  root_q;
  logic [4:0]   scnt_q;
  logic         remz_q;
  logic [63:0]  td_q, dse_q, dss_q, mds_q, three_q;

  logic [31:0]  mul_a, mul_b;
  logic [63:0]  p_d;
  logic         mul_issue, mul_fin;
  logic [32:0]  dt, dr33;
  logic         dge;
  logic [63:0]  q_next;
  logic [31:0]  r_next;
  logic         div_fin;
  logic [34:0]  st, strial, sdiff;
  logic         sge;
  logic [31:0]  root_next;
  logic         sqrt_fin;
  logic [63:0]  td_sat, dss_sat, var_d;
  logic [33:0]  three_d;

  always_comb begin
    mul_a     = mcnt_q[0] ? op_a_q[63:32] : op_a_q[31:0];
    mul_b     = mcnt_q[1] ? op_b_q[63:32] : op_b_q[31:0];
    p_d       = {32'b0, mul_a} * {32'b0, mul_b};
    mul_issue = mcnt_q <= {1'b0, klast_q};
    mul_fin   = mcnt_q == ({1'b0, klast_q} + 3'd1);
    acc_d     = acc_q + (p_vld_q ? ({64'b0, p_q} << {p_sh_q, 5'b0}) : 128'b0);

    dt      = {rem_q, dvd_q[63]};
    dge     = dt >= {1'b0, dvs_q};
    dr33    = dge ? (dt - {1'b0, dvs_q}) : dt;
    r_next  = dr33[31:0];
    q_next  = {dvd_q[62:0], dge};
    div_fin = dcnt_q == 6'd63;

    st        = {srem_q[32:0], rad_q[63:62]};
    strial    = {1'b0, root_q, 2'b01};
    sge       = st >= strial;
    sdiff     = sge ? (st - strial) : st;
    root_next = {root_q[30:0], sge};
    sqrt_fin  = scnt_q == 5'd31;
    three_d   = {1'b0, root_next, 1'b0} + {2'b0, root_next};

    td_sat  = (|acc_d[95:80]) ? '1 : acc_d[79:16];
    dss_sat = (|acc_d[127:96]) ? '1 : acc_d[95:32];
    var_d   = ((|acc_d[127:64]) || (acc_d[63:0] >= mds_q)) ? 64'b0 : (mds_q - acc_d[63:0]);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pcdt_pkg::R_IDLE: begin
        if (req_i.start) begin
          state_d = (req_i.mode == pcdt_pkg::MODE_MOD) ? pcdt_pkg::R_MOD : pcdt_pkg::R_S2;
        end
      end
      pcdt_pkg::R_S2:   if (mul_fin) state_d = pcdt_pkg::R_TD;
      pcdt_pkg::R_TD:   if (mul_fin) state_d = pcdt_pkg::R_DIV1;
      pcdt_pkg::R_DIV1: if (div_fin) state_d = pcdt_pkg::R_DSS;
      pcdt_pkg::R_DSS:  if (mul_fin) state_d = pcdt_pkg::R_DIV2;
      pcdt_pkg::R_DIV2: if (div_fin) state_d = pcdt_pkg::R_SQ;
      pcdt_pkg::R_SQ:   if (mul_fin) state_d = pcdt_pkg::R_DIV3;
      pcdt_pkg::R_DIV3: if (div_fin) state_d = pcdt_pkg::R_SQRT;
      pcdt_pkg::R_SQRT: if (sqrt_fin) state_d = pcdt_pkg::R_DONE;
      pcdt_pkg::R_MOD:  if (div_fin) state_d = pcdt_pkg::R_DONE;
      pcdt_pkg::R_DONE: state_d = pcdt_pkg::R_IDLE;
      default:          state_d = pcdt_pkg::R_IDLE;
    endcase
  end

  always_comb begin
    rsp_o.done     = state_q == pcdt_pkg::R_DONE;
    rsp_o.rem_zero = remz_q;
    row_o.td       = td_q;
    row_o.dse      = dse_q;
    row_o.dss      = dss_q;
    row_o.mds      = mds_q;
    row_o.three    = three_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcdt_pkg::R_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_issue) begin
      p_q     <= p_d;
      p_sh_q  <= {1'b0, mcnt_q[0]} + {1'b0, mcnt_q[1]};
      p_vld_q <= 1'b1;
    end else begin
      p_vld_q <= 1'b0;
    end
    acc_q  <= acc_d;
    mcnt_q <= mcnt_q + 3'd1;

    rem_q  <= r_next;
    dvd_q  <= q_next;
    dcnt_q <= dcnt_q + 6'd1;

    srem_q <= sdiff[33:0];
    root_q <= root_next;
    rad_q  <= {rad_q[61:0], 2'b00};
    scnt_q <= scnt_q + 5'd1;

    unique case (state_q)
      pcdt_pkg::R_IDLE: begin
        run_q <= run_i;
        sq_q  <= sq_i;
        sc_q  <= scale_i;
        n_q   <= (count_i == 32'd0) ? 32'd1 : count_i;
        if (req_i.mode == pcdt_pkg::MODE_MOD) begin
          dvd_q  <= {32'b0, count_i};
          dvs_q  <= (interval_i == 16'd0) ? 32'd1 : {16'b0, interval_i};
          rem_q  <= '0;
          dcnt_q <= '0;
        end else begin
          op_a_q  <= {32'b0, scale_i};
          op_b_q  <= {32'b0, scale_i};
          klast_q <= 2'd0;
          mcnt_q  <= '0;
          acc_q   <= '0;
          p_vld_q <= 1'b0;
        end
      end
      pcdt_pkg::R_S2: begin
        if (mul_fin) begin
          s2_q    <= acc_d[63:0];
          op_a_q  <= run_q;
          op_b_q  <= {32'b0, sc_q};
          klast_q <= 2'd1;
          mcnt_q  <= '0;
          acc_q   <= '0;
          p_vld_q <= 1'b0;
        end
      end
      pcdt_pkg::R_TD: begin
        if (mul_fin) begin
          td_q   <= td_sat;
          dvd_q  <= td_sat;
          dvs_q  <= n_q;
          rem_q  <= '0;
          dcnt_q <= '0;
        end
      end
      pcdt_pkg::R_DIV1: begin
        if (div_fin) begin
          dse_q   <= q_next;
          op_a_q  <= sq_q;
          op_b_q  <= s2_q;
          klast_q <= 2'd3;
          mcnt_q  <= '0;
          acc_q   <= '0;
          p_vld_q <= 1'b0;
        end
      end
      pcdt_pkg::R_DSS: begin
        if (mul_fin) begin
          dss_q  <= dss_sat;
          dvd_q  <= dss_sat;
          rem_q  <= '0;
          dcnt_q <= '0;
        end
      end
      pcdt_pkg::R_DIV2: begin
        if (div_fin) begin
          mds_q   <= q_next;
          op_a_q  <= dse_q;
          op_b_q  <= dse_q;
          klast_q <= 2'd3;
          mcnt_q  <= '0;
          acc_q   <= '0;
          p_vld_q <= 1'b0;
        end
      end
      pcdt_pkg::R_SQ: begin
        if (mul_fin) begin
          dvd_q  <= var_d;
          rem_q  <= '0;
          dcnt_q <= '0;
        end
      end
      pcdt_pkg::R_DIV3: begin
        if (div_fin) begin
          rad_q  <= q_next;
          srem_q <= '0;
          root_q <= '0;
          scnt_q <= '0;
        end
      end
      pcdt_pkg::R_SQRT: begin
        if (sqrt_fin) three_q <= 64'(three_d);
      end
      pcdt_pkg::R_MOD: begin
        if (div_fin) remz_q <= r_next == 32'd0;
      end
      pcdt_pkg::R_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/per_channel_dose_tally.sv
// Deposit: S_DEP follows acceptance before the next request can be taken; an ignored
// deposit stays in S_IDLE. End of event: each channel is read, one holding energy this
// event is squared and written back, then the report check uses the shared divider
// (1 bit per cycle). Report row: multiplier, three divides, 32-step root, output stall.
// Async active-low reset clears control state, valid bits and the channel mask.
module per_channel_dose_tally (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pcdt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [31:0]                       cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              in_op_i,
  input  logic [5:0]                        in_channel_i,
  input  logic [31:0]                       in_energy_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [5:0]                        report_channel_o,
  output logic [63:0]                       total_dose_o,
  output logic [63:0]                       dose_per_event_o,
  output logic [63:0]                       dose_square_sum_o,
  output logic [63:0]                       mean_dose_square_o,
  output logic [63:0]                       three_sigma_o,
  output logic [31:0]                       events_so_far_o,
  output logic                              last_row_o
);

  localparam int NCH = pcdt_pkg::CHANNELS;
  localparam int AW  = pcdt_pkg::AW;

  pcdt_pkg::top_state_e state_q, state_d;

  logic [15:0]     save_interval_q;
  logic [31:0]     dose_scale_q;
  logic [AW-1:0]   idx_q;
  logic [31:0]     e_q;
  logic [NCH-1:0]  touched_q, ev_v_q, sq_v_q;
  logic [31:0]     count_q;
  logic            last_q;
  logic [63:0]     p_q;

  logic [63:0]     run_mem [NCH];
  logic [31:0]     ev_mem  [NCH];
  logic [63:0]     sq_mem  [NCH];
  logic [63:0]     run_rd_q, sq_rd_q;
  logic [31:0]     ev_rd_q;
  logic [AW-1:0]   rd_addr;

  logic            run_we, ev_we, sq_we;
  logic [63:0]     run_wd, sq_wd;
  logic [31:0]     ev_wd;
  logic [64:0]     run_sum, sq_sum;
  logic [32:0]     ev_sum;
  logic [63:0]     run_old, sq_old;
  logic [31:0]     ev_old;

  logic            accept, ch_ok, e_nz, idx_last, more_above;
  pcdt_pkg::req_t  req;
  pcdt_pkg::rsp_t  rsp;
  pcdt_pkg::row_t  row;

  pcdt_row u_row (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .run_i      (run_rd_q),
    .sq_i       (sq_old),
    .scale_i    (dose_scale_q),
    .count_i    (count_q),
    .interval_i (save_interval_q),
    .rsp_o      (rsp),
    .row_o      (row)
  );

  always_comb begin
    accept   = in_valid_i && in_ready_o;
    ch_ok    = {1'b0, in_channel_i} < 7'(NCH);
    e_nz     = |in_energy_i[pcdt_pkg::ENERGY_BITS-1:0];
    idx_last = idx_q == AW'(NCH - 1);
    rd_addr  = (state_q == pcdt_pkg::S_IDLE) ? in_channel_i[AW-1:0] : idx_q;

    more_above = 1'b0;
    for (int j = 0; j < NCH; j++) begin
      if (j > int'(idx_q)) more_above = more_above | touched_q[j];
    end

    run_old = touched_q[idx_q] ? run_rd_q : 64'b0;
    ev_old  = ev_v_q[idx_q] ? ev_rd_q : 32'b0;
    sq_old  = sq_v_q[idx_q] ? sq_rd_q : 64'b0;
    run_sum = {1'b0, run_old} + {33'b0, e_q};
    ev_sum  = {1'b0, ev_old} + {1'b0, e_q};
    sq_sum  = {1'b0, sq_old} + {1'b0, p_q};
    run_wd  = run_sum[64] ? '1 : run_sum[63:0];
    ev_wd   = ev_sum[32] ? '1 : ev_sum[31:0];
    sq_wd   = sq_sum[64] ? '1 : sq_sum[63:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pcdt_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (in_op_i == pcdt_pkg::OP_EOE) state_d = pcdt_pkg::S_EOE_RD;
          else if (e_nz && ch_ok)          state_d = pcdt_pkg::S_DEP;
        end
      end
      pcdt_pkg::S_DEP: state_d = pcdt_pkg::S_IDLE;
      pcdt_pkg::S_EOE_RD: begin
        if (ev_v_q[idx_q]) state_d = pcdt_pkg::S_EOE_MUL;
        else if (idx_last) state_d = pcdt_pkg::S_EOE_END;
      end
      pcdt_pkg::S_EOE_MUL: state_d = pcdt_pkg::S_EOE_WR;
      pcdt_pkg::S_EOE_WR:  state_d = idx_last ? pcdt_pkg::S_EOE_END : pcdt_pkg::S_EOE_RD;
      pcdt_pkg::S_EOE_END: state_d = pcdt_pkg::S_MOD_GO;
      pcdt_pkg::S_MOD_GO:  state_d = pcdt_pkg::S_MOD_WAIT;
      pcdt_pkg::S_MOD_WAIT: begin
        if (rsp.done) state_d = rsp.rem_zero ? pcdt_pkg::S_REP_SCAN : pcdt_pkg::S_IDLE;
      end
      pcdt_pkg::S_REP_SCAN: begin
        if (touched_q[idx_q]) state_d = pcdt_pkg::S_REP_LOAD;
        else if (idx_last)    state_d = pcdt_pkg::S_IDLE;
      end
      pcdt_pkg::S_REP_LOAD: state_d = pcdt_pkg::S_REP_CALC;
      pcdt_pkg::S_REP_CALC: if (rsp.done) state_d = pcdt_pkg::S_REP_OUT;
      pcdt_pkg::S_REP_OUT: begin
        if (out_ready_i) state_d = last_q ? pcdt_pkg::S_IDLE : pcdt_pkg::S_REP_SCAN;
      end
      default: state_d = pcdt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = state_q == pcdt_pkg::S_IDLE;
    out_valid_o = state_q == pcdt_pkg::S_REP_OUT;
    run_we      = state_q == pcdt_pkg::S_DEP;
    ev_we       = state_q == pcdt_pkg::S_DEP;
    sq_we       = state_q == pcdt_pkg::S_EOE_WR;
    req.start   = (state_q == pcdt_pkg::S_MOD_GO) || (state_q == pcdt_pkg::S_REP_LOAD);
    req.mode    = (state_q == pcdt_pkg::S_MOD_GO) ? pcdt_pkg::MODE_MOD : pcdt_pkg::MODE_ROW;

    report_channel_o   = 6'(idx_q);
    total_dose_o       = row.td;
    dose_per_event_o   = row.dse;
    dose_square_sum_o  = row.dss;
    mean_dose_square_o = row.mds;
    three_sigma_o      = row.three;
    events_so_far_o    = count_q;
    last_row_o         = last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      save_interval_q <= pcdt_pkg::SAVE_INTERVAL_RST;
      dose_scale_q    <= pcdt_pkg::DOSE_SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pcdt_pkg::CFG_SAVE_INTERVAL: save_interval_q <= cfg_wdata_i[15:0];
        pcdt_pkg::CFG_DOSE_SCALE:    dose_scale_q    <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pcdt_pkg::S_IDLE;
      idx_q     <= '0;
      touched_q <= '0;
      ev_v_q    <= '0;
      sq_v_q    <= '0;
      count_q   <= '0;
      last_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        pcdt_pkg::S_IDLE: begin
          if (accept) begin
            idx_q <= (in_op_i == pcdt_pkg::OP_EOE) ? '0 : in_channel_i[AW-1:0];
          end
        end
        pcdt_pkg::S_DEP: begin
          touched_q[idx_q] <= 1'b1;
          ev_v_q[idx_q]    <= 1'b1;
        end
        pcdt_pkg::S_EOE_RD: begin
          if (!ev_v_q[idx_q] && !idx_last) idx_q <= idx_q + 1'b1;
        end
        pcdt_pkg::S_EOE_WR: begin
          sq_v_q[idx_q] <= 1'b1;
          if (!idx_last) idx_q <= idx_q + 1'b1;
        end
        pcdt_pkg::S_EOE_END: begin
          ev_v_q <= '0;
          if (count_q != '1) count_q <= count_q + 32'd1;
        end
        pcdt_pkg::S_MOD_WAIT: begin
          if (rsp.done) idx_q <= '0;
        end
        pcdt_pkg::S_REP_SCAN: begin
          if (!touched_q[idx_q] && !idx_last) idx_q <= idx_q + 1'b1;
        end
        pcdt_pkg::S_REP_CALC: begin
          if (rsp.done) last_q <= !more_above;
        end
        pcdt_pkg::S_REP_OUT: begin
          if (out_ready_i && !last_q) idx_q <= idx_q + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) e_q <= 32'(in_energy_i[pcdt_pkg::ENERGY_BITS-1:0]);
    if (state_q == pcdt_pkg::S_EOE_MUL) p_q <= {32'b0, ev_old} * {32'b0, ev_old};
  end

  always_ff @(posedge clk_i) begin
    if (run_we) run_mem[idx_q] <= run_wd;
    run_rd_q <= run_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ev_we) ev_mem[idx_q] <= ev_wd;
    ev_rd_q <= ev_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (sq_we) sq_mem[idx_q] <= sq_wd;
    sq_rd_q <= sq_mem[rd_addr];
  end

endmodule

### rtl/pcdt_checker.sv
module pcdt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        last_row_o,
  input logic [31:0] events_so_far_o,
  input logic [63:0] total_dose_o
);

  // no new request while a report row is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("request taken during report");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_row_o) |=> (!out_valid_o && !in_ready_o) || in_ready_o)
    else $error("row after last row");

  a_count_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (events_so_far_o != 32'd0))
    else $error("report with zero events");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(total_dose_o)))
    else $error("stalled row changed");

endmodule

bind per_channel_dose_tally pcdt_checker u_pcdt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .last_row_o      (last_row_o),
  .events_so_far_o (events_so_far_o),
  .total_dose_o    (total_dose_o)
);

### verif/per_channel_dose_tally_tb.sv
`timescale 1ns / 1ps

module per_channel_dose_tally_tb;

  typedef struct packed {
    logic        op;
    logic [5:0]  channel;
    logic [31:0] energy;
  } deposit_req_t;

  typedef struct packed {
    logic [5:0]  ch;
    logic [63:0] td;
    logic [63:0] dse;
    logic [63:0] dss;
    logic [63:0] mds;
    logic [63:0] three;
    logic [31:0] events;
    logic        last;
  } dose_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [pcdt_pkg::CFG_IDX_W-1:0] cfg_idx_i = pcdt_pkg::CFG_SAVE_INTERVAL;
  logic [31:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic in_op_i = pcdt_pkg::OP_DEPOSIT;
  logic [5:0] in_channel_i = '0;
  logic [31:0] in_energy_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [5:0] report_channel_o;
  logic [63:0] total_dose_o, dose_per_event_o, dose_square_sum_o;
  logic [63:0] mean_dose_square_o, three_sigma_o;
  logic [31:0] events_so_far_o;
  logic last_row_o;

  per_channel_dose_tally dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // tally model
  logic [15:0]  save_every;
  logic [31:0]  scale;
  logic [63:0]  run_e [64];
  logic [31:0]  evt_e [64];
  logic [63:0]  sq_sum [64];
  logic         hit [64];
  logic [31:0]  n_events;

  deposit_req_t req_q[$];
  dose_row_t    rows_q[$];
  int           mismatches = 0;
  bit           stall_long = 1'b0;

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic dose_row_t tally_row(int c);
    dose_row_t   r;
    logic [127:0] p;
    logic [63:0] n, s2, sq;
    n = (n_events != 0) ? {32'd0, n_events} : 64'd1;
    p = {64'd0, run_e[c]} * {96'd0, scale};
    r.td = (p[127:80] != 0) ? '1 : p[79:16];
    r.dse = r.td / n;
    s2 = {32'd0, scale} * {32'd0, scale};
    p = {64'd0, sq_sum[c]} * {64'd0, s2};
    r.dss = (p[127:96] != 0) ? '1 : p[95:32];
    r.mds = r.dss / n;
    p = {64'd0, r.dse} * {64'd0, r.dse};
    sq = (p[127:64] != 0 || p[63:0] >= r.mds) ? 64'd0 : r.mds - p[63:0];
    r.three = 64'd3 * isqrt64(sq / n);
    r.ch = c[5:0];
    r.events = n_events;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic void tally_step(deposit_req_t q);
    logic [64:0] s;
    logic [63:0] sqv;
    logic [15:0] every;
    int          first;
    if (q.op == pcdt_pkg::OP_DEPOSIT) begin
      if (q.energy != 0) begin
        s = {1'b0, run_e[q.channel]} + q.energy;
        run_e[q.channel] = s[64] ? '1 : s[63:0];
        s = {33'd0, evt_e[q.channel]} + q.energy;
        evt_e[q.channel] = s[32] ? '1 : s[31:0];
        hit[q.channel] = 1'b1;
      end
      return;
    end
    for (int c = 0; c < 64; c++) begin
      sqv = {32'd0, evt_e[c]} * {32'd0, evt_e[c]};
      s = {1'b0, sq_sum[c]} + sqv;
      sq_sum[c] = s[64] ? '1 : s[63:0];
      evt_e[c] = 0;
    end
    if (n_events != '1) n_events++;
    every = (save_every != 0) ? save_every : 16'd1;
    if (n_events % every != 0) return;
    first = rows_q.size();
    for (int c = 0; c < 64; c++)
      if (hit[c]) rows_q.push_back(tally_row(c));
    if (rows_q.size() > first) rows_q[rows_q.size()-1].last = 1'b1;
  endfunction

  // driver
  int gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        tally_step('{in_op_i, in_channel_i, in_energy_i});
        gap = $urandom_range(0, 4);
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap > 0 || req_q.size() == 0) begin
          if (gap > 0) gap--;
          in_valid_i <= 1'b0;
        end else begin
          deposit_req_t q;
          q = req_q.pop_front();
          in_valid_i <= 1'b1;
          in_op_i <= q.op;
          in_channel_i <= q.channel;
          in_energy_i <= q.energy;
        end
      end
    end
  end

  // monitor
  int ogap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        dose_row_t got, want;
        got = '{report_channel_o, total_dose_o, dose_per_event_o, dose_square_sum_o,
                mean_dose_square_o, three_sigma_o, events_so_far_o, last_row_o};
        if (rows_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected row ch=%0d", got.ch);
        end else begin
          want = rows_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("row mismatch exp ch=%0d td=%h dse=%h dss=%h mds=%h 3s=%h n=%0d l=%b",
                want.ch, want.td, want.dse, want.dss, want.mds, want.three, want.events,
                want.last);
              $display("  got ch=%0d td=%h dse=%h dss=%h mds=%h 3s=%h n=%0d l=%b",
                got.ch, got.td, got.dse, got.dss, got.mds, got.three, got.events,
                got.last);
            end
          end
        end
        ogap = $urandom_range(0, 4);
      end
      if (stall_long) begin
        out_ready_i <= 1'b0;
      end else if (ogap > 0) begin
        ogap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic cfg_write(logic [pcdt_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == pcdt_pkg::CFG_SAVE_INTERVAL) save_every = val[15:0];
    else scale = val;
  endtask

  task automatic push_req(logic op, logic [5:0] ch, logic [31:0] e);
    req_q.push_back('{op, ch, e});
  endtask

  task automatic drain();
    while (req_q.size() != 0 || in_valid_i || rows_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic random_events(int n_items, int chan_max);
    int k;
    k = 0;
    while (k < n_items) begin
      int nd;
      nd = $urandom_range(0, 5);
      for (int j = 0; j < nd; j++) begin
        logic [31:0] e;
        case ($urandom_range(0, 3))
          0: e = $urandom;
          1: e = $urandom_range(0, 255);
          2: e = '1;
          default: e = $urandom_range(0, 65535);
        endcase
        if ($urandom_range(0, 9) == 0) e = 0;
        push_req(pcdt_pkg::OP_DEPOSIT, $urandom_range(0, chan_max), e);
      end
      push_req(pcdt_pkg::OP_EOE, $urandom, $urandom);
      k += nd + 1;
    end
  endtask

  initial begin
    save_every = pcdt_pkg::SAVE_INTERVAL_RST;
    scale = pcdt_pkg::DOSE_SCALE_RST;
    n_events = 0;
    for (int c = 0; c < 64; c++) begin
      run_e[c] = 0;
      evt_e[c] = 0;
      sq_sum[c] = 0;
      hit[c] = 1'b0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty pass, then extremes
    push_req(pcdt_pkg::OP_EOE, 6'd0, 32'd0);
    push_req(pcdt_pkg::OP_DEPOSIT, 6'd5, 32'd0);
    push_req(pcdt_pkg::OP_EOE, 6'h3f, '1);
    push_req(pcdt_pkg::OP_DEPOSIT, 6'd0, 32'd1);
    push_req(pcdt_pkg::OP_DEPOSIT, 6'd63, '1);
    push_req(pcdt_pkg::OP_DEPOSIT, 6'd63, '1);
    push_req(pcdt_pkg::OP_DEPOSIT, 6'd42, 32'h5555_aaaa);
    push_req(pcdt_pkg::OP_EOE, 6'd0, 32'd0);
    push_req(pcdt_pkg::OP_DEPOSIT, 6'd21, 32'haaaa_5555);
    push_req(pcdt_pkg::OP_EOE, 6'd0, 32'd0);
    drain();

    cfg_write(pcdt_pkg::CFG_DOSE_SCALE, '1);
    cfg_write(pcdt_pkg::CFG_SAVE_INTERVAL, 16'd0);
    push_req(pcdt_pkg::OP_DEPOSIT, 6'd63, '1);
    push_req(pcdt_pkg::OP_EOE, 6'd0, 32'd0);
    push_req(pcdt_pkg::OP_DEPOSIT, 6'd1, 32'd7);
    push_req(pcdt_pkg::OP_EOE, 6'd0, 32'd0);
    drain();

    cfg_write(pcdt_pkg::CFG_DOSE_SCALE, 32'd0);
    cfg_write(pcdt_pkg::CFG_SAVE_INTERVAL, 16'hffff);
    push_req(pcdt_pkg::OP_DEPOSIT, 6'd3, 32'd9);
    push_req(pcdt_pkg::OP_EOE, 6'd0, 32'd0);
    drain();

    cfg_write(pcdt_pkg::CFG_SAVE_INTERVAL, 16'd2);
    cfg_write(pcdt_pkg::CFG_DOSE_SCALE, 32'h0000_8000);
    random_events(60, 7);
    drain();

    // long receiver hold-off while input keeps coming
    cfg_write(pcdt_pkg::CFG_SAVE_INTERVAL, 16'd1);
    cfg_write(pcdt_pkg::CFG_DOSE_SCALE, 32'h0003_1234);
    stall_long = 1'b1;
    random_events(50, 15);
    repeat (3000) @(posedge clk_i);
    stall_long = 1'b0;
    drain();

    cfg_write(pcdt_pkg::CFG_SAVE_INTERVAL, 16'd3);
    cfg_write(pcdt_pkg::CFG_DOSE_SCALE, $urandom);
    random_events(100, 63);
    drain();

    if (mismatches == 0) begin
      $display("[per_channel_dose_tally] OK");
    end else begin
      $display("[per_channel_dose_tally] ERROR");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("[per_channel_dose_tally] ERROR");
    $finish;
  end

endmodule
